>>> rtl/bns_pkg.sv
// Package for the buzzer note sequencer: item types, codes and span divider constants.
`default_nettype none

package bns_pkg;

	localparam int MAX_NOTES_DEF = 32;

	localparam int FREQ_W = 16;
	localparam int MS_W   = 16;
	localparam int VOL_W  = 9;
	localparam int TICK_W = 23;

	localparam logic [TICK_W-1:0] TICK_SAT = '1;
	localparam logic [VOL_W-1:0]  VOL_MIN  = 9'd10;
	localparam logic [VOL_W-1:0]  VOL_MAX  = 9'd256;
	localparam logic [TICK_W-1:0] SPAN_MIN = 23'd2;

	// freq*ms/1000 = ((freq*ms) >> 3) / 125, the /125 done as a reciprocal multiply
	localparam int               PRE_SHIFT = 3;
	localparam int               RECIP_W   = 30;
	localparam logic [RECIP_W-1:0] RECIP_125 = 30'd549755814;
	localparam int               RECIP_SH  = 36;
	localparam int               PROD_W    = FREQ_W + MS_W;
	localparam int               QUOT_W    = PROD_W - PRE_SHIFT;
	localparam int               LO_W      = 15;
	localparam int               HI_W      = QUOT_W - LO_W;
	localparam int               SUM_W     = QUOT_W + RECIP_W;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_SONG = 2'd1,
		CMD_TONE = 2'd2,
		CMD_TICK = 2'd3
	} bns_cmd_t;

	typedef struct packed {
		bns_cmd_t          cmd;
		logic [4:0]        note_index;
		logic [FREQ_W-1:0] note_freq;
		logic [MS_W-1:0]   note_ms;
		logic [VOL_W-1:0]  note_volume;
		logic [5:0]        song_length;
	} bns_in_t;

	typedef struct packed {
		logic [VOL_W-1:0]  buzzer_level;
		logic [FREQ_W-1:0] tick_rate_hz;
		logic              playing;
		logic              accepted;
	} bns_out_t;

	// item leaving the span pipeline, with its tick span worked out
	typedef struct packed {
		bns_in_t           item;
		logic [TICK_W-1:0] span;
	} bns_span_item_t;

	// one note table entry; the span is stored instead of the milliseconds
	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [TICK_W-1:0] span;
		logic [VOL_W-1:0]  vol;
	} bns_note_t;

endpackage

`default_nettype wire

>>> rtl/buzzer_note_sequencer_unit.sv
// Top level of the buzzer note sequencer: span pipeline, note table, player state, result register.
//
//   channel | signals                          | transfer when
//   --------+----------------------------------+---------------------------
//   command | cmd_valid, cmd_ready, cmd_item   | cmd_valid && cmd_ready
//   result  | res_valid, res_ready, res_item   | res_valid && res_ready
//
// One item per cycle while results are taken; from the command transfer to a valid result,
// the transfer loads the input register, then product, partial products, span, result register.
// The player state updates when an item moves from the span stage into the result register.
// A full result register that is not taken stalls only the stages behind it; bubbles close up.
// Reset clears the pipeline valids and the player state; the note table holds no reset.
`default_nettype none

module buzzer_note_sequencer_unit
	import bns_pkg::*;
#(
	parameter int MAX_NOTES = MAX_NOTES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cmd_valid,
	output logic         cmd_ready,
	input  wire bns_in_t cmd_item,
	output logic         res_valid,
	input  wire logic    res_ready,
	output bns_out_t     res_item
);

	localparam int NW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int CW = $clog2(MAX_NOTES + 1);

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_TONE = 2'd1,
		MODE_SONG = 2'd2
	} mode_t;

	logic           item_valid, take;
	bns_span_item_t sit;
	bns_cmd_t       next_cmd;

	logic           wr_en;
	logic [NW-1:0]  wr_addr, rd_addr;
	bns_note_t      wr_data, rd_data;

	mode_t             mode_q, mode_d;
	logic [TICK_W-1:0] elapsed_q, elapsed_d;
	logic [TICK_W-1:0] ticks_q, ticks_d;
	logic [CW-1:0]     cur_q, cur_d;
	logic [CW-1:0]     notes_q, notes_d;
	logic [VOL_W-1:0]  tone_vol_q, tone_vol_d;
	logic [VOL_W-1:0]  note_vol_q, note_vol_d;
	logic [VOL_W-1:0]  level_q, level_d;
	logic [FREQ_W-1:0] rate_q, rate_d;
	logic              acc;
	bns_out_t          res_q;
	logic              res_valid_q;

	bns_span_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd_item   (cmd_item),
		.item_valid (item_valid),
		.item_take  (take),
		.item       (sit),
		.next_cmd   (next_cmd)
	);

	bns_note_table #(
		.MAX_NOTES (MAX_NOTES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign take = item_valid && (!res_valid_q || res_ready);

	assign wr_addr      = NW'(sit.item.note_index);
	assign wr_data.freq = sit.item.note_freq;
	assign wr_data.span = sit.span;
	assign wr_data.vol  = sit.item.note_volume;

	always_comb begin
		logic [TICK_W-1:0] el_inc;
		logic [CW:0]       nxt;
		logic [CW-1:0]     len_sat;
		logic              idx_ok;

		mode_d     = mode_q;
		elapsed_d  = elapsed_q;
		ticks_d    = ticks_q;
		cur_d      = cur_q;
		notes_d    = notes_q;
		tone_vol_d = tone_vol_q;
		note_vol_d = note_vol_q;
		level_d    = level_q;
		rate_d     = rate_q;
		acc        = 1'b1;
		wr_en      = 1'b0;
		el_inc     = (elapsed_q < TICK_SAT) ? elapsed_q + 1'b1 : elapsed_q;
		nxt        = (CW+1)'(cur_q) + 1'b1;
		len_sat    = (32'(sit.item.song_length) > MAX_NOTES) ? CW'(MAX_NOTES)
		                                                     : CW'(sit.item.song_length);
		idx_ok     = 32'(sit.item.note_index) < MAX_NOTES;

		case (sit.item.cmd)
			CMD_LOAD: begin
				wr_en = take && idx_ok;
				// a reload of the sounding note changes its stored volume, used for the level from the next tick on
				if (idx_ok && 32'(sit.item.note_index) == 32'(cur_q)) begin
					note_vol_d = sit.item.note_volume;
				end
			end
			CMD_SONG: begin
				notes_d   = len_sat;
				elapsed_d = '0;
				cur_d     = '0;
				if (len_sat == '0) begin
					mode_d  = MODE_IDLE;
					level_d = '0;
					rate_d  = '0;
				end else begin
					mode_d     = MODE_SONG;
					rate_d     = rd_data.freq;
					ticks_d    = rd_data.span;
					note_vol_d = rd_data.vol;
				end
			end
			CMD_TONE: begin
				elapsed_d = '0;
				if (sit.item.note_volume < VOL_MIN || sit.item.note_volume > VOL_MAX) begin
					acc = 1'b0;
				end else begin
					tone_vol_d = sit.item.note_volume;
					ticks_d    = sit.span;
					if (sit.span < SPAN_MIN) begin
						acc = 1'b0;
					end else begin
						mode_d = MODE_TONE;
						rate_d = sit.item.note_freq;
					end
				end
			end
			CMD_TICK: begin
				if (mode_q != MODE_IDLE) begin
					elapsed_d = el_inc;
					if (el_inc > ticks_q) begin
						if (mode_q == MODE_SONG && nxt < (CW+1)'(notes_q)) begin
							cur_d      = nxt[CW-1:0];
							rate_d     = rd_data.freq;
							elapsed_d  = '0;
							ticks_d    = rd_data.span;
							note_vol_d = rd_data.vol;
						end else begin
							mode_d  = MODE_IDLE;
							level_d = '0;
							rate_d  = '0;
							cur_d   = '0;
						end
					end else if (mode_q == MODE_TONE) begin
						level_d = tone_vol_q & {VOL_W{el_inc[0]}};
					end else begin
						level_d = note_vol_q & {VOL_W{el_inc[0]}};
					end
				end
			end
			default: begin
				acc = 1'b1;
			end
		endcase
	end

	// read address for the item that will be in the span stage next cycle
	always_comb begin
		logic [CW-1:0] cur_next;
		logic [CW:0]   look;

		cur_next = take ? cur_d : cur_q;
		look     = (CW+1)'(cur_next) + 1'b1;
		if (next_cmd == CMD_SONG || 32'(look) >= MAX_NOTES) begin
			rd_addr = '0;
		end else begin
			rd_addr = NW'(look);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			elapsed_q   <= '0;
			ticks_q     <= '0;
			cur_q       <= '0;
			notes_q     <= '0;
			tone_vol_q  <= VOL_MAX;
			note_vol_q  <= '0;
			level_q     <= '0;
			rate_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				mode_q      <= mode_d;
				elapsed_q   <= elapsed_d;
				ticks_q     <= ticks_d;
				cur_q       <= cur_d;
				notes_q     <= notes_d;
				tone_vol_q  <= tone_vol_d;
				note_vol_q  <= note_vol_d;
				level_q     <= level_d;
				rate_q      <= rate_d;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.buzzer_level <= level_d;
			res_q.tick_rate_hz <= rate_d;
			res_q.playing      <= (mode_d != MODE_IDLE);
			res_q.accepted     <= acc;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	a_tone_vol_ok: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_TONE |-> tone_vol_q >= VOL_MIN)
		else $error("tone playing with a volume below the minimum");

	a_song_note_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_SONG |-> cur_q < notes_q)
		else $error("song note index beyond song length");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> (level_q == '0 && rate_q == '0))
		else $error("idle with buzzer level or tick rate not cleared");

endmodule

`default_nettype wire

>>> rtl/bns_span_pipe.sv
// Input register and span pipeline: freq*ms/1000 over three registered stages.
`default_nettype none

module bns_span_pipe
	import bns_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire bns_in_t        cmd_item,
	output logic                item_valid,
	input  wire logic           item_take,
	output bns_span_item_t      item,
	output bns_cmd_t            next_cmd
);

	logic    v_s1, v_s2, v_s3, v_s4;
	logic    rdy1, rdy2, rdy3, rdy4;
	bns_in_t it_s1, it_s2, it_s3, it_s4;
	logic [PROD_W-1:0]        prod_s2;
	logic [LO_W+RECIP_W-1:0]  pp_lo_s3;
	logic [HI_W+RECIP_W-1:0]  pp_hi_s3;
	logic [TICK_W-1:0]        span_s4;
	logic [QUOT_W-1:0]        quot;
	logic [SUM_W-1:0]         sum;

	assign rdy4 = !v_s4 || item_take;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign cmd_ready = rdy1;

	assign quot = prod_s2[PROD_W-1:PRE_SHIFT];
	assign sum  = SUM_W'(pp_lo_s3) + (SUM_W'(pp_hi_s3) << LO_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= cmd_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && cmd_valid) begin
			it_s1 <= cmd_item;
		end
		if (rdy2 && v_s1) begin
			it_s2   <= it_s1;
			prod_s2 <= PROD_W'(it_s1.note_freq) * PROD_W'(it_s1.note_ms);
		end
		if (rdy3 && v_s2) begin
			it_s3    <= it_s2;
			pp_lo_s3 <= (LO_W+RECIP_W)'(quot[LO_W-1:0]) * (LO_W+RECIP_W)'(RECIP_125);
			pp_hi_s3 <= (HI_W+RECIP_W)'(quot[QUOT_W-1:LO_W]) * (HI_W+RECIP_W)'(RECIP_125);
		end
		if (rdy4 && v_s3) begin
			it_s4   <= it_s3;
			span_s4 <= sum[RECIP_SH +: TICK_W];
		end
	end

	assign item_valid = v_s4;
	assign item.item  = it_s4;
	assign item.span  = span_s4;
	// command of the item that will sit in the last stage next cycle
	assign next_cmd   = rdy4 ? it_s3.cmd : it_s4.cmd;

endmodule

`default_nettype wire

>>> rtl/bns_note_table.sv
// Note table: one write port, one registered read port with write bypass.
`default_nettype none

module bns_note_table
	import bns_pkg::*;
#(
	parameter int MAX_NOTES = MAX_NOTES_DEF,
	localparam int NW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [NW-1:0] wr_addr,
	input  wire bns_note_t     wr_data,
	input  wire logic [NW-1:0] rd_addr,
	output bns_note_t          rd_data
);

	bns_note_t mem [MAX_NOTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (wr_en && wr_addr == rd_addr) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire
